### rtl/lmtc_pkg.sv
// Shared types and constants for the LCD mode timing controller.
// Holds the input and result transaction structs and the mode codes; no dependencies.
`default_nettype none

package lmtc_pkg;

    // lcd mode codes as reported in the status register
    localparam logic [1:0] MODE_HBLANK   = 2'd0;
    localparam logic [1:0] MODE_VBLANK   = 2'd1;
    localparam logic [1:0] MODE_OAM      = 2'd2;
    localparam logic [1:0] MODE_TRANSFER = 2'd3;

    // one timing update from the cpu side
    typedef struct packed {
        logic [7:0] cycles;
        logic       screen_on;
        logic [7:0] lyc;
        logic       hblank_irq_en;
        logic       vblank_irq_en;
        logic       oam_irq_en;
        logic       lyc_irq_en;
    } lmtc_in_t;

    // line and mode status after one update
    typedef struct packed {
        logic [7:0] ly;
        logic [1:0] mode;
        logic       coincidence;
        logic       vblank_request;
        logic       stat_request;
        logic       render_start;
    } lmtc_out_t;

endpackage

`default_nettype wire

### rtl/lcd_mode_timing_controller.sv
// LCD line and mode timing controller top level: line clock, line counter, mode and requests.
// Depends on lmtc_pkg for the transaction structs and mode codes.
`default_nettype none

// Takes one timing update per clock and returns one status result per update, in order.
// An update enters an input register; when the result stage advances, the line clock,
// line counter, mode and coincidence state are advanced and the result is written to
// the output register. Both registers hand off in the same cycle, so the sustained
// rate is one update per clock while result_ready stays high; a stall on the result
// side backs up through the two registers to item_ready. The line state feeds back
// on itself only through the result stage, which is what limits the rate to one
// update per cycle.
module lcd_mode_timing_controller #(
    parameter int LINE_CLOCKS   = 457,
    parameter int OAM_CLOCKS    = 80,
    parameter int DRAW_END      = 310,
    parameter int VISIBLE_LINES = 144,
    parameter int LAST_LINE     = 153
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    output logic                item_ready,
    input  lmtc_pkg::lmtc_in_t  item,
    output logic                result_valid,
    input  wire                 result_ready,
    output lmtc_pkg::lmtc_out_t result
);
    import lmtc_pkg::*;

    // clock must hold the largest line clock plus one full cycles step
    localparam int CLK_W = $clog2(LINE_CLOCKS + 256);
    localparam logic [CLK_W-1:0] LINE_CLK = CLK_W'(LINE_CLOCKS);
    localparam logic [CLK_W-1:0] OAM_CLK  = CLK_W'(OAM_CLOCKS);
    localparam logic [CLK_W-1:0] DRAW_CLK = CLK_W'(DRAW_END);
    localparam logic [8:0]       VIS_LINE = 9'(VISIBLE_LINES);
    localparam logic [8:0]       END_LINE = 9'(LAST_LINE);

    // input register
    logic     in_valid_reg;
    lmtc_in_t in_data_reg;

    // line state
    logic [CLK_W-1:0] line_clock_reg;
    logic [CLK_W-1:0] line_clock_next;
    logic [7:0]       line_number_reg;
    logic [7:0]       line_number_next;
    logic [1:0]       mode_reg;
    logic [1:0]       mode_next;
    logic             match_reg;
    logic             match_next;

    // result register
    logic      out_valid_reg;
    lmtc_out_t out_data_reg;
    lmtc_out_t out_data_next;

    logic advance;

    // handshake: result stage moves when its register is free or being drained
    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready   = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            in_data_reg <= item;
        end
    end

    // next line state and result for the transaction in the input register
    always_comb
    begin
        logic [CLK_W-1:0] clk_sum;
        logic [8:0]       line_inc;
        logic             vblank_req;
        logic             stat_req;
        logic             render;

        clk_sum          = line_clock_reg + CLK_W'(in_data_reg.cycles);
        line_inc         = {1'b0, line_number_reg} + 9'd1;
        vblank_req       = 1'b0;
        stat_req         = 1'b0;
        render           = 1'b0;
        line_clock_next  = line_clock_reg;
        line_number_next = line_number_reg;
        mode_next        = mode_reg;
        match_next       = match_reg;

        if (in_data_reg.screen_on)
        begin
            // line change
            if (clk_sum >= LINE_CLK)
            begin
                if (line_inc == VIS_LINE)
                begin
                    mode_next  = MODE_VBLANK;
                    vblank_req = 1'b1;
                    stat_req   = in_data_reg.vblank_irq_en;
                end
                else if (line_inc > END_LINE)
                begin
                    line_inc = 9'd0;
                end
                line_number_next = line_inc[7:0];
                match_next       = (line_inc[7:0] == in_data_reg.lyc);
                if (match_next && in_data_reg.lyc_irq_en)
                begin
                    stat_req = 1'b1;
                end
                clk_sum = clk_sum - LINE_CLK;
            end
            line_clock_next = clk_sum;

            // mode within a visible line
            if ({1'b0, line_number_next} < VIS_LINE)
            begin
                if (clk_sum < OAM_CLK)
                begin
                    if (mode_next != MODE_OAM)
                    begin
                        mode_next = MODE_OAM;
                        if (in_data_reg.oam_irq_en)
                        begin
                            stat_req = 1'b1;
                        end
                    end
                end
                else if (clk_sum < DRAW_CLK)
                begin
                    if (mode_next != MODE_TRANSFER)
                    begin
                        mode_next = MODE_TRANSFER;
                        render    = 1'b1;
                    end
                end
                else if (clk_sum < LINE_CLK)
                begin
                    if (mode_next != MODE_HBLANK)
                    begin
                        mode_next = MODE_HBLANK;
                        if (in_data_reg.hblank_irq_en)
                        begin
                            stat_req = 1'b1;
                        end
                    end
                end
            end
        end
        else
        begin
            // screen off holds line, mode and clock at zero
            line_clock_next  = '0;
            line_number_next = 8'd0;
            mode_next        = MODE_HBLANK;
        end

        out_data_next.ly             = line_number_next;
        out_data_next.mode           = mode_next;
        out_data_next.coincidence    = match_next;
        out_data_next.vblank_request = vblank_req;
        out_data_next.stat_request   = stat_req;
        out_data_next.render_start   = render;
    end

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_clock_reg  <= '0;
            line_number_reg <= 8'd0;
            mode_reg        <= MODE_HBLANK;
            match_reg       <= 1'b0;
        end
        else if (advance)
        begin
            line_clock_reg  <= line_clock_next;
            line_number_reg <= line_number_next;
            mode_reg        <= mode_next;
            match_reg       <= match_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // line clock always stays inside one line
    a_clock_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        line_clock_reg < LINE_CLK)
        else $error("line clock reached line length");

    // render start only on entry to transfer mode
    a_render_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.render_start |-> out_data_reg.mode == MODE_TRANSFER)
        else $error("render start outside transfer mode");

    // vblank request only on entry to the first blanking line
    a_vblank_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.vblank_request |->
            out_data_reg.mode == MODE_VBLANK && out_data_reg.ly == VIS_LINE[7:0])
        else $error("vblank request off the blanking line");

    // a transaction that moves into the result stage shows up as a valid result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after result stage advance");

endmodule

`default_nettype wire
